/* rtl/fcc_pkg.sv */
// ----------------------------------------------------------------------------
// fcc_pkg
// Types and constants shared by the framed message checker core and its port
// checker, and the CRC-32 byte update used by the core.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int unsigned CNT_W    = 33;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [CNT_W-1:0] HDR_BYTES = 33'd16;
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC   = 2'd0,
        CFG_VERSION = 2'd1,
        CFG_RESP    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_LENGTH    = 3'd2,
        VERDICT_MAGIC     = 3'd3,
        VERDICT_VERSION   = 3'd4,
        VERDICT_CRC       = 3'd5
    } t_verdict;

    // Reflected CRC-32, one byte: eight shift/xor steps
    function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

/* rtl/framed_message_crc_checker_core.sv */
// A last byte moves from the input register into the output register, which holds its verdict.
// Throughput: one byte per cycle; the per-byte CRC update is one unrolled byte step.
// Input stalls only when a last byte waits behind a result held by a stalled output.
// Reset (i_rst_n low, synchronous): configuration registers and message state return to their
// cleared values, the CRC accumulator to all ones, and both valid flags drop.
// ----------------------------------------------------------------------------
// framed_message_crc_checker_core
// Captures a 16-byte little-endian header (plus a status byte in response
// mode), runs CRC-32 over the payload and reports one verdict per message.
// ----------------------------------------------------------------------------
module framed_message_crc_checker_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fcc_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    // byte input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    // verdict output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_verdict,
    output logic [7:0]                     o_command_code,
    output logic [7:0]                     o_header_flags,
    output logic [31:0]                    o_payload_length,
    output logic [7:0]                     o_reply_status,
    output logic [31:0]                    o_payload_crc
);

    // configuration registers
    logic [31:0] r_exp_magic;
    logic [15:0] r_exp_version;
    logic        r_resp_mode;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // message state
    logic [fcc_pkg::CNT_W-1:0] r_count,    n_count;
    logic [31:0]               r_crc,      n_crc;
    logic [31:0]               r_magic,    n_magic;
    logic [15:0]               r_version,  n_version;
    logic [7:0]                r_command,  n_command;
    logic [7:0]                r_flags,    n_flags;
    logic [31:0]               r_length,   n_length;
    logic [31:0]               r_checksum, n_checksum;
    logic [7:0]                r_status,   n_status;

    // output register
    logic        r_out_valid;
    logic [2:0]  r_verdict;
    logic [7:0]  r_command_code;
    logic [7:0]  r_header_flags;
    logic [31:0] r_payload_length;
    logic [7:0]  r_reply_status;
    logic [31:0] r_payload_crc;

    logic                      out_free;
    logic                      advance;
    logic                      in_take;
    logic [fcc_pkg::CNT_W-1:0] hdr_len;
    fcc_pkg::t_verdict         verdict;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic   <= '0;
            r_exp_version <= '0;
            r_resp_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fcc_pkg::CFG_MAGIC:   r_exp_magic   <= i_cfg_data;
                fcc_pkg::CFG_VERSION: r_exp_version <= i_cfg_data[15:0];
                fcc_pkg::CFG_RESP:    r_resp_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // classify the byte by its position and fold it into the message state
    always_comb begin
        n_count    = r_count;
        n_crc      = r_crc;
        n_magic    = r_magic;
        n_version  = r_version;
        n_command  = r_command;
        n_flags    = r_flags;
        n_length   = r_length;
        n_checksum = r_checksum;
        n_status   = r_status;

        priority if (r_count < 33'd4) begin
            n_magic[8*r_count[1:0] +: 8] = r_in_byte;
        end else if (r_count < 33'd6) begin
            n_version[8*r_count[0] +: 8] = r_in_byte;
        end else if (r_count == 33'd6) begin
            n_command = r_in_byte;
        end else if (r_count == 33'd7) begin
            n_flags = r_in_byte;
        end else if (r_count < 33'd12) begin
            n_length[8*r_count[1:0] +: 8] = r_in_byte;
        end else if (r_count < fcc_pkg::HDR_BYTES) begin
            n_checksum[8*r_count[1:0] +: 8] = r_in_byte;
        end else if (r_count == fcc_pkg::HDR_BYTES && r_resp_mode) begin
            n_status = r_in_byte;
        end else begin
            n_crc = fcc_pkg::crc_byte(r_crc, r_in_byte);
        end

        if (r_count != fcc_pkg::CNT_MAX) begin
            n_count = r_count + 33'd1;
        end
    end

    assign hdr_len = fcc_pkg::HDR_BYTES + {32'd0, r_resp_mode};

    always_comb begin
        priority if (n_count < hdr_len) begin
            verdict = fcc_pkg::VERDICT_SHORT;
        end else if ({1'b0, n_count} != ({1'b0, hdr_len} + {2'b00, n_length})) begin
            verdict = fcc_pkg::VERDICT_LENGTH;
        end else if (n_magic != r_exp_magic) begin
            verdict = fcc_pkg::VERDICT_MAGIC;
        end else if (n_version != r_exp_version) begin
            verdict = fcc_pkg::VERDICT_VERSION;
        end else if (~n_crc != n_checksum) begin
            verdict = fcc_pkg::VERDICT_CRC;
        end else begin
            verdict = fcc_pkg::VERDICT_OK;
        end
    end

    // clear the message state after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_count    <= '0;
            r_crc      <= fcc_pkg::CRC_INIT;
            r_magic    <= '0;
            r_version  <= '0;
            r_command  <= '0;
            r_flags    <= '0;
            r_length   <= '0;
            r_checksum <= '0;
            r_status   <= '0;
        end else if (advance) begin
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_magic    <= n_magic;
            r_version  <= n_version;
            r_command  <= n_command;
            r_flags    <= n_flags;
            r_length   <= n_length;
            r_checksum <= n_checksum;
            r_status   <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_verdict        <= verdict;
            r_command_code   <= n_command;
            r_header_flags   <= n_flags;
            r_payload_length <= n_length;
            r_reply_status   <= r_resp_mode ? n_status : 8'd0;
            r_payload_crc    <= ~n_crc;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_verdict        = r_verdict;
    assign o_command_code   = r_command_code;
    assign o_header_flags   = r_header_flags;
    assign o_payload_length = r_payload_length;
    assign o_reply_status   = r_reply_status;
    assign o_payload_crc    = r_payload_crc;

endmodule

/* rtl/fcc_checker.sv */
// ----------------------------------------------------------------------------
// fcc_checker
// Port-level checks for the framed message checker core, bound to the core module.
// ----------------------------------------------------------------------------
module fcc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [fcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [fcc_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic [7:0]                     i_data_byte,
    input logic                           i_last_byte,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [2:0]                     o_verdict,
    input logic [7:0]                     o_command_code,
    input logic [7:0]                     o_header_flags,
    input logic [31:0]                    o_payload_length,
    input logic [7:0]                     o_reply_status,
    input logic [31:0]                    o_payload_crc
);

    // a verdict held by a stalled output stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("verdict dropped while stalled");

    // a stalled verdict keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_verdict) && $stable(o_payload_crc)
            && $stable(o_payload_length) && $stable(o_reply_status))
        else $error("verdict payload changed while stalled");

    // input backpressure only arises behind a held, stalled verdict
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with a free output");

    // reset leaves no verdict pending
    a_reset_clear: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("valid state survived reset");

endmodule

bind framed_message_crc_checker_core fcc_checker u_fcc_checker (.*);
